/* rtl/core/rth_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pkg
// Types and constants shared by the RGB to HSV conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int PIPE_STAGES = 11;
  localparam int DIV_STAGES  = 8;
  localparam int DIV_QW      = 16;
  localparam int DIV_BPS     = DIV_QW / DIV_STAGES;
  localparam int NUM_W       = 25;
  localparam int DEN_W       = 9;
  localparam int HUE_FRAC    = 4;

  localparam logic [NUM_W-1:0] HUE_SPAN2  = 25'd7680;
  localparam logic [NUM_W-1:0] SAT_SCALE2 = 25'd131070;
  localparam logic [14:0]      HUE_OFF_RED_NEG = 15'd23040;
  localparam logic [14:0]      HUE_OFF_GREEN   = 15'd7680;
  localparam logic [14:0]      HUE_OFF_BLUE    = 15'd15360;
  localparam logic [15:0]      HUE_TURN        = 16'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] d;
    logic [7:0] a;
    sector_t    sector;
    logic       neg;
  } front_t;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [DIV_QW-1:0] lo;
    logic [DEN_W-1:0]  den;
  } div_lane_t;

  typedef struct packed {
    logic [7:0]  bright;
    logic [14:0] hue_off;
    logic        neg;
    logic        grey;
    logic        black;
  } div_side_t;

  typedef struct packed {
    div_lane_t hue;
    div_lane_t sat;
    div_side_t side;
  } div_word_t;

endpackage : rth_pkg
`default_nettype wire

/* rtl/core/rth_pix_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pix_if
// Stream channel that carries one RGB pixel word.
// ----------------------------------------------------------------------------
interface rth_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface : rth_pix_if
`default_nettype wire

/* rtl/core/rth_hsv_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_hsv_if
// Stream channel that carries one HSV result word.
// ----------------------------------------------------------------------------
interface rth_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface : rth_hsv_if
`default_nettype wire

/* rtl/core/rth_ctl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_ctl
// Valid bits and per-stage load enables of the conversion pipeline.
// ----------------------------------------------------------------------------
module rth_ctl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rth_pkg::PIPE_STAGES-1:0]     ld
);
  import rth_pkg::*;

  logic [PIPE_STAGES-1:0] valid_r;
  logic [PIPE_STAGES-1:0] valid_nxt;
  logic [PIPE_STAGES:0]   rdy;

  always_comb begin
    rdy[PIPE_STAGES] = out_ready;
    for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < PIPE_STAGES; i++) begin
      if (rdy[i]) begin
        valid_nxt[i] = (i == 0) ? in_valid : valid_r[(i == 0) ? 0 : i - 1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ld        = rdy[PIPE_STAGES-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = valid_r[PIPE_STAGES-1];

endmodule : rth_ctl
`default_nettype wire

/* rtl/core/rth_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_front
// Finds max, min, sector and channel difference, then forms the dividends
// and divisors for the hue and saturation dividers.
// ----------------------------------------------------------------------------
module rth_front (
  input  wire logic               clk,
  input  wire logic [1:0]         ld,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  output rth_pkg::div_word_t      word_o
);
  import rth_pkg::*;

  front_t    f_r;
  front_t    f_nxt;
  div_word_t w_r;
  div_word_t w_nxt;
  logic [7:0]       mn;
  logic [NUM_W-1:0] hnum;
  logic [NUM_W-1:0] snum;

  always_comb begin
    f_nxt = '0;
    if (red >= green && red >= blue) begin
      f_nxt.sector = SEC_RED;
    end else if (green >= blue) begin
      f_nxt.sector = SEC_GREEN;
    end else begin
      f_nxt.sector = SEC_BLUE;
    end
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    case (f_nxt.sector)
      SEC_RED: begin
        f_nxt.mx  = red;
        f_nxt.neg = green < blue;
        f_nxt.a   = f_nxt.neg ? blue - green : green - blue;
      end
      SEC_GREEN: begin
        f_nxt.mx  = green;
        f_nxt.neg = blue < red;
        f_nxt.a   = f_nxt.neg ? red - blue : blue - red;
      end
      SEC_BLUE: begin
        f_nxt.mx  = blue;
        f_nxt.neg = red < green;
        f_nxt.a   = f_nxt.neg ? green - red : red - green;
      end
      default: begin
        f_nxt.mx  = red;
        f_nxt.neg = 1'b0;
        f_nxt.a   = '0;
      end
    endcase
    f_nxt.d = f_nxt.mx - mn;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      f_r <= f_nxt;
    end
  end

  // A falling difference rounds halves down, so one is taken off its dividend.
  always_comb begin
    w_nxt = '0;
    hnum  = (NUM_W'(f_r.a) * HUE_SPAN2 + NUM_W'(f_r.d) - NUM_W'(f_r.neg)) << HUE_FRAC;
    snum  = NUM_W'(f_r.d) * SAT_SCALE2 + NUM_W'(f_r.mx);
    w_nxt.hue.rem = hnum[NUM_W-1:DIV_QW];
    w_nxt.hue.lo  = hnum[DIV_QW-1:0];
    w_nxt.hue.den = {f_r.d, 1'b0};
    w_nxt.sat.rem = snum[NUM_W-1:DIV_QW];
    w_nxt.sat.lo  = snum[DIV_QW-1:0];
    w_nxt.sat.den = {f_r.mx, 1'b0};
    w_nxt.side.bright = f_r.mx;
    w_nxt.side.neg    = f_r.neg;
    w_nxt.side.grey   = (f_r.d == 8'd0);
    w_nxt.side.black  = (f_r.mx == 8'd0);
    case (f_r.sector)
      SEC_RED:   w_nxt.side.hue_off = f_r.neg ? HUE_OFF_RED_NEG : 15'd0;
      SEC_GREEN: w_nxt.side.hue_off = HUE_OFF_GREEN;
      SEC_BLUE:  w_nxt.side.hue_off = HUE_OFF_BLUE;
      default:   w_nxt.side.hue_off = 15'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      w_r <= w_nxt;
    end
  end

  assign word_o = w_r;

endmodule : rth_front
`default_nettype wire

/* rtl/core/rth_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_div
// Pipelined restoring divider that runs the hue and saturation quotients
// side by side, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module rth_div (
  input  wire logic                           clk,
  input  wire logic [rth_pkg::DIV_STAGES-1:0] ld,
  input  wire rth_pkg::div_word_t             word_i,
  output rth_pkg::div_word_t                  word_o
);
  import rth_pkg::*;

  div_word_t stage_r [DIV_STAGES];

  function automatic div_lane_t div_iter(input div_lane_t l);
    div_lane_t        n;
    logic [DEN_W:0]   t;
    logic             q;
    n = l;
    t = {l.rem, l.lo[DIV_QW-1]};
    q = (t >= {1'b0, l.den});
    if (q) begin
      t = t - {1'b0, l.den};
    end
    n.rem = t[DEN_W-1:0];
    n.lo  = {l.lo[DIV_QW-2:0], q};
    return n;
  endfunction

  function automatic div_word_t div_stage(input div_word_t w);
    div_word_t n;
    n = w;
    for (int k = 0; k < DIV_BPS; k++) begin
      n.hue = div_iter(n.hue);
      n.sat = div_iter(n.sat);
    end
    return n;
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_word_t stage_nxt;
    if (s == 0) begin : g_first
      assign stage_nxt = div_stage(word_i);
    end else begin : g_next
      assign stage_nxt = div_stage(stage_r[s-1]);
    end
    always_ff @(posedge clk) begin
      if (ld[s]) begin
        stage_r[s] <= stage_nxt;
      end
    end
  end

  assign word_o = stage_r[DIV_STAGES-1];

endmodule : rth_div
`default_nettype wire

/* rtl/core/rth_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_back
// Adds the hue quotient to the sector offset or subtracts it, wraps a full
// turn, forces the grey and black cases and holds the result word.
// ----------------------------------------------------------------------------
module rth_back (
  input  wire logic               clk,
  input  wire logic               ld,
  input  wire rth_pkg::div_word_t word_i,
  output logic [14:0]             hue,
  output logic [15:0]             saturation,
  output logic [7:0]              brightness
);
  import rth_pkg::*;

  logic [14:0] hue_r;
  logic [14:0] hue_nxt;
  logic [15:0] sat_r;
  logic [15:0] sat_nxt;
  logic [7:0]  bright_r;
  logic [15:0] q;
  logic [15:0] hsum;

  always_comb begin
    q = {{HUE_FRAC{1'b0}}, word_i.hue.lo[DIV_QW-1:HUE_FRAC]};
    if (word_i.side.neg) begin
      hsum = {1'b0, word_i.side.hue_off} - q;
    end else begin
      hsum = {1'b0, word_i.side.hue_off} + q;
    end
    if (hsum >= HUE_TURN) begin
      hsum = hsum - HUE_TURN;
    end
    hue_nxt = word_i.side.grey ? 15'd0 : hsum[14:0];
    sat_nxt = word_i.side.black ? 16'd0 : word_i.sat.lo;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= word_i.side.bright;
    end
  end

  assign hue        = hue_r;
  assign saturation = sat_r;
  assign brightness = bright_r;

endmodule : rth_back
`default_nettype wire

/* rtl/core/rgb_to_hsv_converter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Converts a stream of 8-bit RGB pixels to hue, saturation and value.
// Throughput is one word per cycle while the output is not stalled;
// the 8-stage divider pair sets the depth.
// Under backpressure bubbles collapse; a full stage waits for space ahead.
// Reset clears only the stage valid bits; the datapath needs no reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rth_pix_if.sink     in_pix,
  rth_hsv_if.source   out_hsv
);
  import rth_pkg::*;

  logic [PIPE_STAGES-1:0] ld;
  div_word_t              front_word;
  div_word_t              div_word;

  rth_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_hsv.valid),
    .out_ready (out_hsv.ready),
    .ld        (ld)
  );

  rth_front u_front (
    .clk    (clk),
    .ld     (ld[1:0]),
    .red    (in_pix.red),
    .green  (in_pix.green),
    .blue   (in_pix.blue),
    .word_o (front_word)
  );

  rth_div u_div (
    .clk    (clk),
    .ld     (ld[DIV_STAGES+1:2]),
    .word_i (front_word),
    .word_o (div_word)
  );

  rth_back u_back (
    .clk        (clk),
    .ld         (ld[PIPE_STAGES-1]),
    .word_i     (div_word),
    .hue        (out_hsv.hue),
    .saturation (out_hsv.saturation),
    .brightness (out_hsv.brightness)
  );

endmodule : rgb_to_hsv_converter_core
`default_nettype wire
